### rtl/core/tcwl_pkg.sv
// Shared codes, register map and reset values for the text cursor wrap layout core.
package tcwl_pkg;

	localparam int COORD_BITS_DEF = 8;

	localparam int CFG_ADDR_BITS  = 5;
	localparam int CFG_DATA_BITS  = 32;
	localparam int CFG_INDEX_BITS = 3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_AREA_LEFT    = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AREA_TOP     = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AREA_RIGHT   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AREA_BOTTOM  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CELL_WIDTH   = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CELL_HEIGHT  = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_LEADING = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CHAR_SPACING = 3'd7;

	localparam logic [7:0] RST_AREA_LEFT    = 8'd0;
	localparam logic [7:0] RST_AREA_TOP     = 8'd0;
	localparam logic [7:0] RST_AREA_RIGHT   = 8'd127;
	localparam logic [7:0] RST_AREA_BOTTOM  = 8'd63;
	localparam logic [7:0] RST_CELL_WIDTH   = 8'd5;
	localparam logic [7:0] RST_CELL_HEIGHT  = 8'd8;
	localparam logic [7:0] RST_LINE_LEADING = 8'd1;
	localparam logic [7:0] RST_CHAR_SPACING = 8'd1;

	localparam logic [7:0] CODE_END = 8'd0;
	localparam logic [7:0] CODE_NL  = 8'd10;
	localparam logic [7:0] CODE_SP  = 8'd32;

	localparam int ACT_BITS = 3;

	localparam logic [ACT_BITS-1:0] ACT_DRAW = 3'd0;
	localparam logic [ACT_BITS-1:0] ACT_SKIP = 3'd1;
	localparam logic [ACT_BITS-1:0] ACT_STOP = 3'd2;
	localparam logic [ACT_BITS-1:0] ACT_TERM = 3'd3;
	localparam logic [ACT_BITS-1:0] ACT_IGN  = 3'd4;

endpackage

### rtl/core/text_cursor_wrap_layout_core.sv
// Top level of the text cursor wrap layout core: cursor update, result register, APB registers.
//
//  channel | direction | handshake           | words
//  --------+-----------+---------------------+------------------------------------------
//  in      | to core   | in_valid, in_stall  | char_code, string_start, final_char
//  out     | from core | out_valid, out_stall| action, pos_x, pos_y, consumed, done_res
//  apb     | to core   | psel, penable       | paddr, pwrite, pwdata, prdata, pready
//
// One word per cycle while in_stall is low: the cursor, halt flag and count update in the
// cycle a word is accepted, and its result is loaded into the output register with them.
// The cursor path (one add and compare on the x edge, then on the y edge) sets the cycle.
// in_stall rises only while a held result is stalled at the output.
// Reset clears the cursor, halt flag, count and output valid, and loads register defaults.
module text_cursor_wrap_layout_core #(
	parameter int COORD_BITS = tcwl_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         char_code,
	input  logic                               string_start,
	input  logic                               final_char,

	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [tcwl_pkg::ACT_BITS-1:0]      action,
	output logic [7:0]                         pos_x,
	output logic [7:0]                         pos_y,
	output logic [7:0]                         consumed,
	output logic                               done_res,

	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tcwl_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [tcwl_pkg::CFG_DATA_BITS-1:0] pwdata,
	output logic [tcwl_pkg::CFG_DATA_BITS-1:0] prdata,
	output logic                               pready
);
	import tcwl_pkg::*;

	localparam int SUM_BITS = COORD_BITS + 1;

	logic [7:0] area_left_q, area_top_q, area_right_q, area_bottom_q;
	logic [7:0] cell_width_q, cell_height_q, line_leading_q, char_spacing_q;

	logic [COORD_BITS-1:0] cursor_x_q, cursor_y_q;
	logic                  halted_q;
	logic [7:0]            char_count_q;

	logic [CFG_INDEX_BITS-1:0] cfg_idx;
	logic                      cfg_wr;

	logic                  in_take;
	logic [COORD_BITS-1:0] left_c, top_c;
	logic [COORD_BITS-1:0] cx, cy, cx1, cy1, cy_wrap;
	logic                  hlt;
	logic [7:0]            cnt;
	logic                  wrap, skip, stop;
	logic [SUM_BITS-1:0]   x_edge, y_edge;

	logic [COORD_BITS-1:0] nxt_x, nxt_y;
	logic                  nxt_halted;
	logic [7:0]            nxt_count;
	logic [ACT_BITS-1:0]   nxt_act;
	logic [7:0]            nxt_px, nxt_py;
	logic                  nxt_done;

	// APB registers
	assign pready  = 1'b1;
	assign cfg_idx = paddr[CFG_ADDR_BITS-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_left_q    <= RST_AREA_LEFT;
			area_top_q     <= RST_AREA_TOP;
			area_right_q   <= RST_AREA_RIGHT;
			area_bottom_q  <= RST_AREA_BOTTOM;
			cell_width_q   <= RST_CELL_WIDTH;
			cell_height_q  <= RST_CELL_HEIGHT;
			line_leading_q <= RST_LINE_LEADING;
			char_spacing_q <= RST_CHAR_SPACING;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_AREA_LEFT:    area_left_q    <= pwdata[7:0];
				REG_AREA_TOP:     area_top_q     <= pwdata[7:0];
				REG_AREA_RIGHT:   area_right_q   <= pwdata[7:0];
				REG_AREA_BOTTOM:  area_bottom_q  <= pwdata[7:0];
				REG_CELL_WIDTH:   cell_width_q   <= pwdata[7:0];
				REG_CELL_HEIGHT:  cell_height_q  <= pwdata[7:0];
				REG_LINE_LEADING: line_leading_q <= pwdata[7:0];
				REG_CHAR_SPACING: char_spacing_q <= pwdata[7:0];
				default:          area_left_q    <= area_left_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_AREA_LEFT:    prdata[7:0] = area_left_q;
			REG_AREA_TOP:     prdata[7:0] = area_top_q;
			REG_AREA_RIGHT:   prdata[7:0] = area_right_q;
			REG_AREA_BOTTOM:  prdata[7:0] = area_bottom_q;
			REG_CELL_WIDTH:   prdata[7:0] = cell_width_q;
			REG_CELL_HEIGHT:  prdata[7:0] = cell_height_q;
			REG_LINE_LEADING: prdata[7:0] = line_leading_q;
			REG_CHAR_SPACING: prdata[7:0] = char_spacing_q;
			default:          prdata      = '0;
		endcase
	end

	// cursor update
	assign in_stall = out_valid && out_stall;
	assign in_take  = in_valid && !in_stall;

	assign left_c = COORD_BITS'(area_left_q);
	assign top_c  = COORD_BITS'(area_top_q);

	always_comb begin
		cx  = string_start ? left_c : cursor_x_q;
		cy  = string_start ? top_c  : cursor_y_q;
		hlt = string_start ? 1'b0   : halted_q;
		cnt = string_start ? 8'd0   : char_count_q;

		x_edge  = SUM_BITS'(cx) + SUM_BITS'(cell_width_q);
		wrap    = (x_edge > SUM_BITS'(area_right_q)) || (char_code == CODE_NL);
		cy_wrap = cy + COORD_BITS'(cell_height_q) + COORD_BITS'(line_leading_q);
		cx1     = wrap ? left_c  : cx;
		cy1     = wrap ? cy_wrap : cy;
		skip    = wrap && ((char_code == CODE_SP) || (char_code == CODE_NL));
		y_edge  = SUM_BITS'(cy1) + SUM_BITS'(cell_height_q);
		stop    = y_edge >= SUM_BITS'(area_bottom_q);

		nxt_x      = cx;
		nxt_y      = cy;
		nxt_halted = hlt;
		nxt_count  = cnt;
		nxt_act    = ACT_IGN;
		nxt_px     = 8'd0;
		nxt_py     = 8'd0;
		nxt_done   = 1'b0;

		priority if (hlt) begin
			nxt_act = ACT_IGN;
		end else if (char_code == CODE_END) begin
			nxt_act    = ACT_TERM;
			nxt_done   = 1'b1;
			nxt_halted = 1'b1;
		end else if (skip) begin
			nxt_act    = ACT_SKIP;
			nxt_x      = cx1;
			nxt_y      = cy1;
			nxt_count  = cnt + 8'd1;
			nxt_done   = final_char;
			nxt_halted = final_char;
		end else if (stop) begin
			nxt_act    = ACT_STOP;
			nxt_x      = cx1;
			nxt_y      = cy1;
			nxt_done   = 1'b1;
			nxt_halted = 1'b1;
		end else begin
			nxt_act    = ACT_DRAW;
			nxt_px     = cx1[7:0];
			nxt_py     = cy1[7:0];
			nxt_x      = cx1 + COORD_BITS'(cell_width_q) + COORD_BITS'(char_spacing_q);
			nxt_y      = cy1;
			nxt_count  = cnt + 8'd1;
			nxt_done   = final_char;
			nxt_halted = final_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q   <= '0;
			cursor_y_q   <= '0;
			halted_q     <= 1'b0;
			char_count_q <= 8'd0;
		end else if (in_take) begin
			cursor_x_q   <= nxt_x;
			cursor_y_q   <= nxt_y;
			halted_q     <= nxt_halted;
			char_count_q <= nxt_count;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!in_stall) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action   <= nxt_act;
			pos_x    <= nxt_px;
			pos_y    <= nxt_py;
			consumed <= nxt_count;
			done_res <= nxt_done;
		end
	end

	a_take_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> out_valid)
		else $error("accepted word produced no result");

	a_done_halts: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && nxt_done |=> halted_q)
		else $error("string ended without halting");

	a_end_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((action == ACT_TERM) || (action == ACT_STOP)) |-> done_res)
		else $error("terminator or stop without done");

	a_pos_only_on_draw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action != ACT_DRAW) |-> (pos_x == 8'd0) && (pos_y == 8'd0))
		else $error("position given for a word that was not drawn");

	a_ignored_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ACT_IGN) |-> !done_res && (consumed == char_count_q))
		else $error("ignored word changed count or ended string");

endmodule

### verif/text_cursor_wrap_layout_checker.sv
// Checker for the text cursor wrap layout core: tracks registers, predicts each result, compares.
`timescale 1ns / 100ps
module text_cursor_wrap_layout_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [7:0]                          char_code,
	input  logic                                string_start,
	input  logic                                final_char,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [tcwl_pkg::ACT_BITS-1:0]       action,
	input  logic [7:0]                          pos_x,
	input  logic [7:0]                          pos_y,
	input  logic [7:0]                          consumed,
	input  logic                                done_res,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tcwl_pkg::CFG_ADDR_BITS-1:0]  paddr,
	input  logic [tcwl_pkg::CFG_DATA_BITS-1:0]  pwdata,
	input  logic [tcwl_pkg::CFG_DATA_BITS-1:0]  prdata,
	input  logic                                pready,
	output int                                  mismatches,
	output int                                  awaiting
);
	import tcwl_pkg::*;

	typedef struct packed {
		logic [ACT_BITS-1:0] act;
		logic [7:0]          px;
		logic [7:0]          py;
		logic [7:0]          count;
		logic                done;
	} layout_word_t;

	layout_word_t layout_q[$];
	layout_word_t want;

	logic [7:0] regs [8];
	logic [7:0] cur_x;
	logic [7:0] cur_y;
	logic [7:0] char_total;
	logic       halted;
	logic [CFG_INDEX_BITS-1:0] reg_idx;

	initial begin
		mismatches = 0;
		awaiting = 0;
	end

	function automatic layout_word_t place_char(input logic [7:0] code, input logic start,
			input logic last);
		layout_word_t w;
		logic         skip;
		logic [8:0]   x_reach;
		logic [8:0]   y_reach;
		w = '0;
		skip = 1'b0;
		if (start) begin
			cur_x = regs[REG_AREA_LEFT];
			cur_y = regs[REG_AREA_TOP];
			halted = 1'b0;
			char_total = 8'd0;
		end
		if (halted) begin
			w.act = ACT_IGN;
		end else if (code == CODE_END) begin
			w.act = ACT_TERM;
			w.done = 1'b1;
		end else begin
			x_reach = {1'b0, cur_x} + {1'b0, regs[REG_CELL_WIDTH]};
			if (x_reach > {1'b0, regs[REG_AREA_RIGHT]} || code == CODE_NL) begin
				cur_x = regs[REG_AREA_LEFT];
				cur_y = cur_y + regs[REG_CELL_HEIGHT] + regs[REG_LINE_LEADING];
				skip = (code == CODE_SP) || (code == CODE_NL);
			end
			y_reach = {1'b0, cur_y} + {1'b0, regs[REG_CELL_HEIGHT]};
			if (skip) begin
				w.act = ACT_SKIP;
				char_total = char_total + 8'd1;
				w.done = last;
			end else if (y_reach >= {1'b0, regs[REG_AREA_BOTTOM]}) begin
				w.act = ACT_STOP;
				w.done = 1'b1;
			end else begin
				w.act = ACT_DRAW;
				w.px = cur_x;
				w.py = cur_y;
				cur_x = cur_x + regs[REG_CELL_WIDTH] + regs[REG_CHAR_SPACING];
				char_total = char_total + 8'd1;
				w.done = last;
			end
			if (w.done)
				halted = 1'b1;
		end
		if (w.act == ACT_TERM)
			halted = 1'b1;
		w.count = char_total;
		return w;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_val, got_val);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs[REG_AREA_LEFT]    = RST_AREA_LEFT;
			regs[REG_AREA_TOP]     = RST_AREA_TOP;
			regs[REG_AREA_RIGHT]   = RST_AREA_RIGHT;
			regs[REG_AREA_BOTTOM]  = RST_AREA_BOTTOM;
			regs[REG_CELL_WIDTH]   = RST_CELL_WIDTH;
			regs[REG_CELL_HEIGHT]  = RST_CELL_HEIGHT;
			regs[REG_LINE_LEADING] = RST_LINE_LEADING;
			regs[REG_CHAR_SPACING] = RST_CHAR_SPACING;
			cur_x = 8'd0;
			cur_y = 8'd0;
			char_total = 8'd0;
			halted = 1'b0;
			layout_q.delete();
			awaiting <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (layout_q.size() == 0) begin
					$display("%0t: unexpected word, action expected none actual %0d",
						$time, action);
					mismatches++;
				end else begin
					want = layout_q.pop_front();
					compare_field("action", want.act, action);
					compare_field("pos_x", want.px, pos_x);
					compare_field("pos_y", want.py, pos_y);
					compare_field("consumed", want.count, consumed);
					compare_field("done_res", want.done, done_res);
				end
			end
			if (psel && penable && pready) begin
				reg_idx = paddr[CFG_ADDR_BITS-1:2];
				if (pwrite)
					regs[reg_idx] = pwdata[7:0];
				else
					compare_field("prdata", {24'd0, regs[reg_idx]}, prdata);
			end
			if (in_valid && !in_stall)
				layout_q.push_back(place_char(char_code, string_start, final_char));
			awaiting <= layout_q.size();
		end
	end

endmodule

### verif/tb_text_cursor_wrap_layout_core.sv
// Testbench top for the text cursor wrap layout core: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_text_cursor_wrap_layout_core;
	import tcwl_pkg::*;

	localparam int IDLE_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] char_code;
	logic string_start;
	logic final_char;
	logic out_valid;
	logic out_stall;
	logic [ACT_BITS-1:0] action;
	logic [7:0] pos_x;
	logic [7:0] pos_y;
	logic [7:0] consumed;
	logic done_res;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_BITS-1:0] paddr;
	logic [CFG_DATA_BITS-1:0] pwdata;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic pready;

	int mismatches;
	int awaiting;
	int idle_cycles = 0;
	int sent = 0;
	int target;
	int phase;
	int stall_len;
	bit steady_input = 1'b0;
	logic [7:0] cfg [8];

	text_cursor_wrap_layout_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.char_code(char_code), .string_start(string_start), .final_char(final_char),
		.out_valid(out_valid), .out_stall(out_stall),
		.action(action), .pos_x(pos_x), .pos_y(pos_y), .consumed(consumed),
		.done_res(done_res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	text_cursor_wrap_layout_checker layout_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.char_code(char_code), .string_start(string_start), .final_char(final_char),
		.out_valid(out_valid), .out_stall(out_stall),
		.action(action), .pos_x(pos_x), .pos_y(pos_y), .consumed(consumed),
		.done_res(done_res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.mismatches(mismatches), .awaiting(awaiting)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] text_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return CODE_SP;
		else if (r < 18)
			return CODE_NL;
		return 8'($urandom_range(33, 126));
	endfunction

	task automatic send_char(input logic [7:0] code, input logic start, input logic last);
		int gap;
		in_valid <= 1'b1;
		char_code <= code;
		string_start <= start;
		final_char <= last;
		do @(posedge clk); while (in_stall);
		sent++;
		gap = steady_input ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text(input int len);
		int i;
		int ending;
		ending = $urandom_range(0, 9);
		for (i = 0; i < len; i++)
			send_char(text_char(), i == 0, (ending < 4) && (i == len - 1));
		if (ending >= 4 && ending < 8)
			send_char(CODE_END, 1'b0, 1'($urandom_range(0, 1)));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input int idx, input logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= CFG_ADDR_BITS'(idx * 4);
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_layout();
		int r;
		for (r = 0; r < 8; r++)
			apb_access(1'b1, r, cfg[r]);
		for (r = 0; r < 8; r++)
			apb_access(1'b0, r, 8'd0);
	endtask

	task automatic pick_layout();
		int r;
		int lim;
		if ($urandom_range(0, 4) == 0) begin
			for (r = 0; r < 8; r++)
				cfg[r] = 8'($urandom_range(0, 255));
		end else begin
			cfg[REG_AREA_LEFT] = 8'($urandom_range(0, 30));
			cfg[REG_AREA_TOP] = 8'($urandom_range(0, 30));
			lim = cfg[REG_AREA_LEFT] + $urandom_range(0, 200);
			cfg[REG_AREA_RIGHT] = 8'((lim > 255) ? 255 : lim);
			lim = cfg[REG_AREA_TOP] + $urandom_range(0, 200);
			cfg[REG_AREA_BOTTOM] = 8'((lim > 255) ? 255 : lim);
			cfg[REG_CELL_WIDTH] = 8'($urandom_range(1, 12));
			cfg[REG_CELL_HEIGHT] = 8'($urandom_range(1, 16));
			cfg[REG_LINE_LEADING] = 8'($urandom_range(0, 4));
			cfg[REG_CHAR_SPACING] = 8'($urandom_range(0, 4));
		end
	endtask

	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 9) == 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(100, 300)) @(posedge clk);
			end else begin
				stall_len = pick_gap();
				out_stall <= (stall_len != 0);
				repeat ((stall_len > 0) ? stall_len : 1) @(posedge clk);
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("FAIL text_cursor_wrap_layout_core");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = 8'd0;
		string_start = 1'b0;
		final_char = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset layout, no string start yet
		send_char("H", 1'b0, 1'b0);
		send_char(CODE_END, 1'b0, 1'b0);
		send_char("Q", 1'b0, 1'b0);
		send_char("A", 1'b1, 1'b1);
		send_char("B", 1'b0, 1'b0);
		drain();

		cfg[REG_AREA_LEFT] = 8'd2;
		cfg[REG_AREA_TOP] = 8'd3;
		cfg[REG_AREA_RIGHT] = 8'd20;
		cfg[REG_AREA_BOTTOM] = 8'd40;
		cfg[REG_CELL_WIDTH] = 8'd5;
		cfg[REG_CELL_HEIGHT] = 8'd8;
		cfg[REG_LINE_LEADING] = 8'd1;
		cfg[REG_CHAR_SPACING] = 8'd1;
		program_layout();
		send_char("a", 1'b1, 1'b0);
		send_char(CODE_SP, 1'b0, 1'b0);
		send_char("c", 1'b0, 1'b0);
		send_char(CODE_SP, 1'b0, 1'b0);
		send_char("d", 1'b0, 1'b0);
		send_char(CODE_NL, 1'b0, 1'b0);
		send_char("e", 1'b0, 1'b0);
		send_char("f", 1'b0, 1'b0);
		send_char("g", 1'b0, 1'b0);
		send_char("h", 1'b0, 1'b0);
		send_char(CODE_NL, 1'b0, 1'b0);
		send_char("z", 1'b0, 1'b0);
		send_char("k", 1'b0, 1'b0);
		send_char(8'd255, 1'b1, 1'b0);
		send_char(CODE_END, 1'b1, 1'b1);
		send_char(CODE_NL, 1'b1, 1'b1);
		send_char(8'd128, 1'b0, 1'b0);
		send_char(8'd127, 1'b1, 1'b1);

		for (phase = 0; phase < 11; phase++) begin
			drain();
			if (phase == 0) begin
				foreach (cfg[r]) cfg[r] = 8'd0;
			end else if (phase == 1) begin
				foreach (cfg[r]) cfg[r] = 8'd255;
			end else if (phase == 2) begin
				cfg[REG_AREA_LEFT] = 8'($urandom_range(0, 255));
				cfg[REG_AREA_TOP] = 8'd0;
				cfg[REG_AREA_RIGHT] = 8'd255;
				cfg[REG_AREA_BOTTOM] = 8'd255;
				cfg[REG_CELL_WIDTH] = 8'd0;
				cfg[REG_CELL_HEIGHT] = 8'd0;
				cfg[REG_LINE_LEADING] = 8'($urandom_range(0, 3));
				cfg[REG_CHAR_SPACING] = 8'($urandom_range(1, 3));
			end else begin
				pick_layout();
			end
			program_layout();
			steady_input = ($urandom_range(0, 3) == 0);
			// hold one string past 256 characters so the count rolls over
			if (phase == 2)
				send_text(300);
			target = sent + ((phase < 2) ? 40 : 110);
			while (sent < target) begin
				if ($urandom_range(0, 99) == 0)
					drain();
				if ($urandom_range(0, 99) < 80) begin
					send_text(($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
						: $urandom_range(1, 30));
				end else begin
					repeat ($urandom_range(1, 5))
						send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
							$urandom_range(0, 3) == 0);
				end
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && awaiting == 0)
			$display("PASS text_cursor_wrap_layout_core");
		else
			$display("FAIL text_cursor_wrap_layout_core");
		$finish;
	end

endmodule

### files.f
rtl/core/tcwl_pkg.sv
rtl/core/text_cursor_wrap_layout_core.sv
verif/text_cursor_wrap_layout_checker.sv
verif/tb_text_cursor_wrap_layout_core.sv
